FILE: rtl/core/aes_stream_pkg.sv
// Types, constants and AES round functions shared by the stream engine core
package aes_stream_pkg;

  localparam int unsigned BLOCK_BYTES = 16;
  localparam int unsigned NUM_ROUNDS  = 10;

  localparam logic [2:0] REG_KEY_UPPER = 3'd0;
  localparam logic [2:0] REG_KEY_LOWER = 3'd1;
  localparam logic [2:0] REG_SV_UPPER  = 3'd2;
  localparam logic [2:0] REG_SV_LOWER  = 3'd3;
  localparam logic [2:0] REG_MODE      = 3'd4;
  localparam logic [2:0] REG_DIRECTION = 3'd5;

  localparam logic REQ_BYTE   = 1'b0;
  localparam logic REQ_FINISH = 1'b1;
  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;
  localparam logic MODE_CBC = 1'b0;
  localparam logic MODE_CTR = 1'b1;
  localparam logic DIR_ENC = 1'b0;
  localparam logic DIR_DEC = 1'b1;

  typedef struct packed {
    logic       req_type;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic       result_kind;
    logic [7:0] out_byte;
    logic       run_last;
    logic [7:0] pad_length;
    logic       pad_error;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_RESTART,
    ST_EXPAND,
    ST_IDLE,
    ST_INIT,
    ST_ROUND,
    ST_FINAL,
    ST_EMIT,
    ST_STATUS
  } state_t;

  localparam logic [2047:0] SBOX_TBL = {
    128'h637c777bf26b6fc53001672bfed7ab76, 128'hca82c97dfa5947f0add4a2af9ca472c0,
    128'hb7fd9326363ff7cc34a5e5f171d83115, 128'h04c723c31896059a071280e2eb27b275,
    128'h09832c1a1b6e5aa0523bd6b329e32f84, 128'h53d100ed20fcb15b6acbbe394a4c58cf,
    128'hd0efaafb434d338545f9027f503c9fa8, 128'h51a3408f929d38f5bcb6da2110fff3d2,
    128'hcd0c13ec5f974417c4a77e3d645d1973, 128'h60814fdc222a908846eeb814de5e0bdb,
    128'he0323a0a4906245cc2d3ac629195e479, 128'he7c8376d8dd54ea96c56f4ea657aae08,
    128'hba78252e1ca6b4c6e8dd741f4bbd8b8a, 128'h703eb5664803f60e613557b986c11d9e,
    128'he1f8981169d98e949b1e87e9ce5528df, 128'h8ca1890dbfe6426841992d0fb054bb16};

  localparam logic [2047:0] INV_SBOX_TBL = {
    128'h52096ad53036a538bf40a39e81f3d7fb, 128'h7ce339829b2fff87348e4344c4dee9cb,
    128'h547b9432a6c2233dee4c950b42fac34e, 128'h082ea16628d924b2765ba2496d8bd125,
    128'h72f8f66486689816d4a45ccc5d65b692, 128'h6c704850fdedb9da5e154657a78d9d84,
    128'h90d8ab008cbcd30af7e45805b8b34506, 128'hd02c1e8fca3f0f02c1afbd0301138a6b,
    128'h3a9111414f67dcea97f2cfcef0b4e673, 128'h96ac7422e7ad3585e2f937e81c75df6e,
    128'h47f11a711d29c5896fb7620eaa18be1b, 128'hfc563e4bc6d279209adbc0fe78cd5af4,
    128'h1fdda8338807c731b11210592780ec5f, 128'h60517fa919b54a0d2de57a9f93c99cef,
    128'ha0e03b4dae2af5b0c8ebbb3c83539961, 128'h172b047eba77d626e169146355210c7d};

  function automatic logic [7:0] sbox(input logic [7:0] x);
    return SBOX_TBL[11'd2047 - {x, 3'b000} -: 8];
  endfunction

  function automatic logic [7:0] inv_sbox(input logic [7:0] x);
    return INV_SBOX_TBL[11'd2047 - {x, 3'b000} -: 8];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] get_byte(input logic [127:0] s, input int i);
    return s[127 - 8 * i -: 8];
  endfunction

  function automatic logic [127:0] fwd_round(input logic [127:0] s, input logic [127:0] k,
                                             input logic last);
    logic [7:0] b [16];
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3;
    logic [127:0] r;
    for (int i = 0; i < 16; i++) b[i] = sbox(get_byte(s, i));
    for (int c = 0; c < 4; c++)
      for (int w = 0; w < 4; w++) t[w + 4 * c] = b[w + 4 * ((c + w) % 4)];
    if (!last) begin
      for (int c = 0; c < 4; c++) begin
        a0 = t[4 * c]; a1 = t[4 * c + 1]; a2 = t[4 * c + 2]; a3 = t[4 * c + 3];
        t[4 * c]     = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
        t[4 * c + 1] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
        t[4 * c + 2] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
        t[4 * c + 3] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
      end
    end
    for (int i = 0; i < 16; i++) r[127 - 8 * i -: 8] = t[i];
    return r ^ k;
  endfunction

  function automatic logic [7:0] inv_mul(input logic [7:0] a, input logic [1:0] sel);
    logic [7:0] m2, m4, m8;
    m2 = xtime(a);
    m4 = xtime(m2);
    m8 = xtime(m4);
    case (sel)
      2'd0:    return m8 ^ m4 ^ m2;
      2'd1:    return m8 ^ m2 ^ a;
      2'd2:    return m8 ^ m4 ^ a;
      default: return m8 ^ a;
    endcase
  endfunction

  function automatic logic [127:0] inv_round(input logic [127:0] s, input logic [127:0] k,
                                             input logic last);
    logic [7:0] b [16];
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3;
    logic [127:0] r;
    for (int c = 0; c < 4; c++)
      for (int w = 0; w < 4; w++) t[w + 4 * ((c + w) % 4)] = get_byte(s, w + 4 * c);
    for (int i = 0; i < 16; i++) b[i] = inv_sbox(t[i]) ^ get_byte(k, i);
    if (!last) begin
      for (int c = 0; c < 4; c++) begin
        a0 = b[4 * c]; a1 = b[4 * c + 1]; a2 = b[4 * c + 2]; a3 = b[4 * c + 3];
        b[4 * c]     = inv_mul(a0, 2'd0) ^ inv_mul(a1, 2'd1) ^ inv_mul(a2, 2'd2)
                       ^ inv_mul(a3, 2'd3);
        b[4 * c + 1] = inv_mul(a0, 2'd3) ^ inv_mul(a1, 2'd0) ^ inv_mul(a2, 2'd1)
                       ^ inv_mul(a3, 2'd2);
        b[4 * c + 2] = inv_mul(a0, 2'd2) ^ inv_mul(a1, 2'd3) ^ inv_mul(a2, 2'd0)
                       ^ inv_mul(a3, 2'd1);
        b[4 * c + 3] = inv_mul(a0, 2'd1) ^ inv_mul(a1, 2'd2) ^ inv_mul(a2, 2'd3)
                       ^ inv_mul(a3, 2'd0);
      end
    end
    for (int i = 0; i < 16; i++) r[127 - 8 * i -: 8] = b[i];
    return r;
  endfunction

  function automatic logic [127:0] key_step(input logic [127:0] p, input logic [7:0] rcon);
    logic [31:0] t, n0, n1, n2, n3;
    t  = {sbox(p[23:16]) ^ rcon, sbox(p[15:8]), sbox(p[7:0]), sbox(p[31:24])};
    n0 = p[127:96] ^ t;
    n1 = p[95:64] ^ n0;
    n2 = p[63:32] ^ n1;
    n3 = p[31:0] ^ n2;
    return {n0, n1, n2, n3};
  endfunction

endpackage

FILE: rtl/core/aes_cbc_ctr_stream_engine_core.sv
// AES-128 CBC/CTR byte stream engine with PKCS#7 padding, iterative round unit
// Usage:
//   in channel: one item per message byte or a finish request (in_valid/in_stall).
//   out channel: 16 data items per processed block, or one status item on a
//   decrypt finish (out_valid/out_stall). run_last marks the last item of a run.
//   cfg channel: register index and 64-bit data; cfg_ready is always high.
//   Write registers only while idle; every write to a register index up to 5 restarts the message.
// Sequence:
//   A byte that does not complete a block is buffered and the engine stays idle.
//   A block passes through a load state, the round states of the shared round
//   unit and a finish state, then 16 output items.
//   A restart (after reset, a register write, or finish) loads the key, then
//   runs key expansion, one round key per cycle.
// The input is stalled from the block load until the last output item is taken.
// A stalled output item holds; the engine waits in place.
// Reset clears the registers, then runs the restart sequence.
module aes_cbc_ctr_stream_engine_core (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  aes_stream_pkg::in_item_t  in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output aes_stream_pkg::out_item_t out_data,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [2:0]                cfg_index,
  input  logic [63:0]               cfg_wdata
);

  aes_stream_pkg::state_t state_r, state_nxt;

  logic [127:0] key_r, sv_r;
  logic         mode_r, dir_r;
  logic [127:0] rk_r [11];
  logic [127:0] prev_key_r;
  logic [7:0]   rcon_r;
  logic [3:0]   cnt_r;
  logic [4:0]   fill_r;
  logic [7:0]   buf_r [16];
  logic [127:0] blk_r, chain_r, aes_r, res_r, last_r;
  logic         fin_r;
  logic [7:0]   pad_r;
  logic         bad_r;

  logic         in_acc, out_acc, cfg_wr, full_blk, inv_aes;
  logic [3:0]   rk_idx;
  logic [127:0] blk_in, buf_vec, aes_in, res_val;
  logic [31:0]  ctr_le;
  logic         bad_chk;

  assign cfg_ready = 1'b1;
  assign cfg_wr  = cfg_valid && (cfg_index <= aes_stream_pkg::REG_DIRECTION);
  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;
  assign inv_aes = (mode_r == aes_stream_pkg::MODE_CBC) && (dir_r == aes_stream_pkg::DIR_DEC);
  assign full_blk = (in_data.req_type == aes_stream_pkg::REQ_BYTE) && (fill_r == 5'd15);

  always_comb begin
    for (int i = 0; i < 16; i++) buf_vec[127 - 8 * i -: 8] = buf_r[i];
  end

  always_comb begin
    blk_in = buf_vec;
    if (in_data.req_type == aes_stream_pkg::REQ_BYTE) begin
      blk_in[7:0] = in_data.data_byte;
    end else begin
      for (int i = 0; i < 16; i++) begin
        if (5'(i) >= fill_r) blk_in[127 - 8 * i -: 8] = 8'd16 - {3'b000, fill_r};
      end
    end
  end

  always_comb begin
    if (mode_r == aes_stream_pkg::MODE_CTR) aes_in = chain_r;
    else if (inv_aes) aes_in = blk_r;
    else aes_in = blk_r ^ chain_r;
  end

  always_comb begin
    if (state_r == aes_stream_pkg::ST_INIT) rk_idx = inv_aes ? 4'd10 : 4'd0;
    else rk_idx = inv_aes ? 4'd10 - cnt_r : cnt_r;
  end

  always_comb begin
    if (mode_r == aes_stream_pkg::MODE_CTR) res_val = blk_r ^ aes_r;
    else if (inv_aes) res_val = aes_r ^ chain_r;
    else res_val = aes_r;
  end

  assign ctr_le = {chain_r[103:96], chain_r[111:104], chain_r[119:112], chain_r[127:120]}
                  + 32'd1;

  always_comb begin
    bad_chk = (last_r[7:0] == 8'd0) || (last_r[7:0] > 8'd16);
    for (int i = 0; i < 16; i++) begin
      if ((8'(i) < last_r[7:0]) && (last_r[8 * i +: 8] != last_r[7:0])) bad_chk = 1'b1;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      aes_stream_pkg::ST_RESTART: state_nxt = aes_stream_pkg::ST_EXPAND;
      aes_stream_pkg::ST_EXPAND: begin
        if (cnt_r == 4'd10) state_nxt = aes_stream_pkg::ST_IDLE;
      end
      aes_stream_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_data.req_type == aes_stream_pkg::REQ_FINISH) begin
            state_nxt = (dir_r == aes_stream_pkg::DIR_DEC) ? aes_stream_pkg::ST_STATUS
                                                           : aes_stream_pkg::ST_INIT;
          end else if (full_blk) begin
            state_nxt = aes_stream_pkg::ST_INIT;
          end
        end
      end
      aes_stream_pkg::ST_INIT: state_nxt = aes_stream_pkg::ST_ROUND;
      aes_stream_pkg::ST_ROUND: begin
        if (cnt_r == 4'd10) state_nxt = aes_stream_pkg::ST_FINAL;
      end
      aes_stream_pkg::ST_FINAL: state_nxt = aes_stream_pkg::ST_EMIT;
      aes_stream_pkg::ST_EMIT: begin
        if (out_acc && cnt_r == 4'd15) begin
          state_nxt = fin_r ? aes_stream_pkg::ST_RESTART : aes_stream_pkg::ST_IDLE;
        end
      end
      aes_stream_pkg::ST_STATUS: begin
        if (out_acc) state_nxt = aes_stream_pkg::ST_RESTART;
      end
      default: state_nxt = aes_stream_pkg::ST_RESTART;
    endcase
    if (cfg_wr) state_nxt = aes_stream_pkg::ST_RESTART;
  end

  always_comb begin
    in_stall  = (state_r != aes_stream_pkg::ST_IDLE);
    out_valid = (state_r == aes_stream_pkg::ST_EMIT) || (state_r == aes_stream_pkg::ST_STATUS);
    out_data  = '0;
    if (state_r == aes_stream_pkg::ST_STATUS) begin
      out_data.result_kind = aes_stream_pkg::KIND_STATUS;
      out_data.run_last    = 1'b1;
      out_data.pad_length  = pad_r;
      out_data.pad_error   = bad_r;
    end else begin
      out_data.result_kind = aes_stream_pkg::KIND_DATA;
      out_data.out_byte    = res_r[127 - {cnt_r, 3'b000} -: 8];
      out_data.run_last    = (cnt_r == 4'd15);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= aes_stream_pkg::ST_RESTART;
      key_r   <= '0;
      sv_r    <= '0;
      mode_r  <= aes_stream_pkg::MODE_CBC;
      dir_r   <= aes_stream_pkg::DIR_ENC;
      cnt_r   <= '0;
      fill_r  <= '0;
      fin_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr) begin
        case (cfg_index)
          aes_stream_pkg::REG_KEY_UPPER: key_r[127:64] <= cfg_wdata;
          aes_stream_pkg::REG_KEY_LOWER: key_r[63:0]   <= cfg_wdata;
          aes_stream_pkg::REG_SV_UPPER:  sv_r[127:64]  <= cfg_wdata;
          aes_stream_pkg::REG_SV_LOWER:  sv_r[63:0]    <= cfg_wdata;
          aes_stream_pkg::REG_MODE:      mode_r        <= cfg_wdata[0];
          aes_stream_pkg::REG_DIRECTION: dir_r         <= cfg_wdata[0];
          default: ;
        endcase
      end
      case (state_r)
        aes_stream_pkg::ST_RESTART: begin
          cnt_r  <= 4'd1;
          fill_r <= '0;
          fin_r  <= 1'b0;
        end
        aes_stream_pkg::ST_EXPAND: cnt_r <= cnt_r + 4'd1;
        aes_stream_pkg::ST_IDLE: begin
          if (in_acc) begin
            if (in_data.req_type == aes_stream_pkg::REQ_FINISH) begin
              fin_r <= 1'b1;
            end else if (full_blk) begin
              fill_r <= '0;
            end else begin
              fill_r <= fill_r + 5'd1;
            end
          end
        end
        aes_stream_pkg::ST_INIT:  cnt_r <= 4'd1;
        aes_stream_pkg::ST_ROUND: cnt_r <= cnt_r + 4'd1;
        aes_stream_pkg::ST_FINAL: cnt_r <= 4'd0;
        aes_stream_pkg::ST_EMIT: begin
          if (out_acc) cnt_r <= cnt_r + 4'd1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      aes_stream_pkg::ST_RESTART: begin
        rk_r[0]    <= key_r;
        prev_key_r <= key_r;
        rcon_r     <= 8'h01;
        chain_r    <= sv_r;
        last_r     <= '0;
      end
      aes_stream_pkg::ST_EXPAND: begin
        rk_r[cnt_r] <= aes_stream_pkg::key_step(prev_key_r, rcon_r);
        prev_key_r  <= aes_stream_pkg::key_step(prev_key_r, rcon_r);
        rcon_r      <= aes_stream_pkg::xtime(rcon_r);
      end
      aes_stream_pkg::ST_IDLE: begin
        if (in_acc) begin
          buf_r[fill_r[3:0]] <= in_data.data_byte;
          blk_r <= blk_in;
          pad_r <= last_r[7:0];
          bad_r <= bad_chk;
        end
      end
      aes_stream_pkg::ST_INIT: aes_r <= aes_in ^ rk_r[rk_idx];
      aes_stream_pkg::ST_ROUND: begin
        aes_r <= inv_aes ? aes_stream_pkg::inv_round(aes_r, rk_r[rk_idx], cnt_r == 4'd10)
                         : aes_stream_pkg::fwd_round(aes_r, rk_r[rk_idx], cnt_r == 4'd10);
      end
      aes_stream_pkg::ST_FINAL: begin
        res_r <= res_val;
        if (mode_r == aes_stream_pkg::MODE_CTR) begin
          chain_r[127:96] <= {ctr_le[7:0], ctr_le[15:8], ctr_le[23:16], ctr_le[31:24]};
        end else if (inv_aes) begin
          chain_r <= blk_r;
        end else begin
          chain_r <= res_val;
        end
        if (dir_r == aes_stream_pkg::DIR_DEC) last_r <= res_val;
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_out_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input open while output pending");
  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == aes_stream_pkg::ST_IDLE) |-> !fill_r[4])
    else $error("buffer fill out of range");
  a_status_dir: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == aes_stream_pkg::ST_STATUS) |-> (dir_r == aes_stream_pkg::DIR_DEC))
    else $error("status item while encrypting");
`endif

endmodule
